[design/sfs_pkg.sv]
// Shared types, constants and rounding helper for the sawtooth Fourier synthesizer.
// No dependencies; used by every module of the block.
`default_nettype none

package sfs_pkg;

    localparam int MAX_HARMONICS = 128;
    localparam int INDEX_BITS    = 16;
    localparam int K_W           = $clog2(MAX_HARMONICS);
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int DIV_W         = 56;
    localparam int DIV_CHUNK     = 8;
    localparam int DIV_STEPS     = DIV_W / DIV_CHUNK;

    localparam logic [7:0] REG_AMPLITUDE      = 8'd0;
    localparam logic [7:0] REG_PHASE_STEP     = 8'd1;
    localparam logic [7:0] REG_HARMONIC_COUNT = 8'd2;
    localparam logic [7:0] REG_REVERSE_MODE   = 8'd3;

    localparam logic [1:0] CLS_RUN  = 2'd0;
    localparam logic [1:0] CLS_ZERO = 2'd1;
    localparam logic [1:0] CLS_ERR  = 2'd2;

    localparam logic signed [32:0] Q30_ONE     = 33'sd1073741824;
    localparam logic signed [32:0] PI_Q30      = 33'sd3373259426;
    localparam logic signed [32:0] TWO_OVER_PI = 33'sd683565276;
    localparam logic signed [32:0] SC3 = -33'sd178956841;
    localparam logic signed [32:0] SC5 = 33'sd8946590;
    localparam logic signed [32:0] SC7 = -33'sd209544;
    localparam logic signed [32:0] CC4 = 33'sd44739220;
    localparam logic signed [32:0] CC6 = -33'sd1491139;
    localparam logic signed [32:0] CC8 = 33'sd26235;

    typedef logic signed [65:0] t_prod;

    typedef struct packed {
        logic [1:0]  cls;
        logic [31:0] step_d;
    } t_item;

    typedef struct packed {
        logic signed [23:0] amplitude;
        logic [7:0]         harmonic_count;
        logic               reverse_mode;
    } t_cfg;

    function automatic t_prod rnd30(input t_prod v);
        t_prod m;
        m = v[65] ? -v : v;
        m = (m + 66'sd536870912) >>> 30;
        return v[65] ? -m : m;
    endfunction

endpackage

`default_nettype wire

[design/sfs_front.sv]
// Front stage: accepts sample requests, classifies them and forms the per-harmonic phase step.
// Depends on sfs_pkg.
`default_nettype none

module sfs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [sfs_pkg::INDEX_BITS-1:0] i_sample_index,
    input  wire logic [31:0]                   i_phase_step,
    input  wire logic [7:0]                    i_harmonic_count,
    output logic                               o_push,
    output sfs_pkg::t_item                     o_item,
    input  wire logic                          i_push_ready
);

    logic           r_valid;
    sfs_pkg::t_item r_item;
    logic [sfs_pkg::INDEX_BITS+31:0] w_prod;

    assign w_prod  = i_sample_index * i_phase_step;
    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.step_d <= w_prod[31:0];
            if (i_harmonic_count > 8'(sfs_pkg::MAX_HARMONICS)) begin
                r_item.cls <= sfs_pkg::CLS_ERR;
            end else if (i_harmonic_count < 8'd2) begin
                r_item.cls <= sfs_pkg::CLS_ZERO;
            end else begin
                r_item.cls <= sfs_pkg::CLS_RUN;
            end
        end
    end

endmodule

`default_nettype wire

[design/sfs_fifo.sv]
// Short request queue between the front and back stages.
// Depends on sfs_pkg.
`default_nettype none

module sfs_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sfs_pkg::t_item i_item,
    output logic                o_ready,
    output logic                o_valid,
    output sfs_pkg::t_item      o_item,
    input  wire logic           i_pop
);

    sfs_pkg::t_item r_mem [sfs_pkg::FIFO_DEPTH];
    logic [sfs_pkg::FIFO_AW-1:0] r_wp;
    logic [sfs_pkg::FIFO_AW-1:0] r_rp;
    logic [sfs_pkg::FIFO_AW:0]   r_cnt;
    logic w_push;
    logic w_pop;

    assign o_ready = r_cnt != (sfs_pkg::FIFO_AW+1)'(sfs_pkg::FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

[design/sfs_back.sv]
// Back stage: per-harmonic sine and scale on one shared multiplier, then divide and accumulate.
// Depends on sfs_pkg; holds the output register.
`default_nettype none

module sfs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  wire sfs_pkg::t_item i_item,
    output logic                o_item_pop,
    input  wire sfs_pkg::t_cfg  i_cfg,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_sample_value,
    output logic                o_status
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_S0   = 4'd1;
    localparam logic [3:0] ST_S1   = 4'd2;
    localparam logic [3:0] ST_S2   = 4'd3;
    localparam logic [3:0] ST_S3   = 4'd4;
    localparam logic [3:0] ST_S4   = 4'd5;
    localparam logic [3:0] ST_S5   = 4'd6;
    localparam logic [3:0] ST_S6   = 4'd7;
    localparam logic [3:0] ST_S7   = 4'd8;
    localparam logic [3:0] ST_DIV  = 4'd9;
    localparam logic [3:0] ST_ACC  = 4'd10;
    localparam logic [3:0] ST_FIN0 = 4'd11;
    localparam logic [3:0] ST_FIN1 = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    logic [3:0]                 r_state;
    logic                       r_ovalid;
    logic [31:0]                r_oval;
    logic                       r_ostat;
    logic [31:0]                r_res;
    logic                       r_rstat;
    logic [31:0]                r_ph;
    logic [31:0]                r_d;
    logic [sfs_pkg::K_W-1:0]    r_k;
    logic signed [57:0]         r_sum;
    sfs_pkg::t_prod             r_p;
    logic signed [32:0]         r_x;
    logic signed [32:0]         r_z;
    logic signed [32:0]         r_w;
    logic [1:0]                 r_q;
    logic                       r_neg;
    logic                       r_tneg;
    logic [sfs_pkg::DIV_W-1:0]  r_div;
    logic [sfs_pkg::DIV_W-1:0]  r_quo;
    logic [sfs_pkg::K_W-1:0]    r_rem;
    logic [$clog2(sfs_pkg::DIV_STEPS)-1:0] r_cnt;

    logic [1:0]         w_q;
    logic [31:0]        w_dd;
    logic [31:0]        w_a;
    logic               w_odd;
    logic signed [32:0] w_rp30;
    logic signed [32:0] w_xn;
    logic signed [32:0] w_w3;
    logic signed [32:0] w_w4;
    logic signed [32:0] w_cos;
    logic signed [32:0] w_sinv;
    logic signed [32:0] w_sinv2;
    logic signed [32:0] w_sine;
    logic signed [32:0] w_s16;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    sfs_pkg::t_prod     w_xfull;
    sfs_pkg::t_prod     w_mag;
    sfs_pkg::t_prod     w_y;
    sfs_pkg::t_prod     w_yn;
    logic [31:0]        w_sat;
    logic [sfs_pkg::K_W-1:0]       w_rem;
    logic [sfs_pkg::DIV_CHUNK-1:0] w_qbyte;
    logic [sfs_pkg::K_W:0]         w_rr;
    logic signed [57:0]            w_term;
    logic                          w_out_free;

    assign w_q     = 2'((r_ph + 32'h2000_0000) >> 30);
    assign w_dd    = r_ph - {w_q, 30'b0};
    assign w_a     = w_dd[31] ? (32'd0 - w_dd) : w_dd;
    assign w_odd   = r_q[0];
    assign w_rp30  = 33'(sfs_pkg::rnd30(r_p));
    assign w_xfull = (r_p + 66'sd1073741824) >>> 31;
    assign w_xn    = w_xfull[32:0];
    assign w_w3    = w_rp30 + (w_odd ? sfs_pkg::CC6 : sfs_pkg::SC5);
    assign w_w4    = w_rp30 + (w_odd ? sfs_pkg::CC4 : sfs_pkg::SC3);
    assign w_cos   = sfs_pkg::Q30_ONE - ((r_z + 33'sd1) >>> 1) + w_rp30;
    assign w_sinv  = r_x + w_rp30;
    assign w_sinv2 = r_neg ? -w_sinv : w_sinv;
    assign w_sine  = w_odd ? ((r_q == 2'd3) ? -w_cos : w_cos)
                           : ((r_q == 2'd2) ? -w_sinv2 : w_sinv2);
    assign w_s16   = 33'(sfs_pkg::rnd30(66'(r_sum)));
    assign w_mag   = r_p[65] ? -r_p : r_p;
    assign w_y     = sfs_pkg::rnd30(r_p);
    assign w_yn    = i_cfg.reverse_mode ? w_y : -w_y;
    assign w_term  = {2'b0, r_quo};
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        if (w_yn > 66'sd2147483647) begin
            w_sat = 32'h7FFF_FFFF;
        end else if (w_yn < -66'sd2147483648) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = w_yn[31:0];
        end
    end

    always_comb begin
        w_rem   = r_rem;
        w_qbyte = '0;
        w_rr    = '0;
        for (int i = 0; i < sfs_pkg::DIV_CHUNK; i++) begin
            w_rr = {w_rem, r_div[sfs_pkg::DIV_W-1-i]};
            if (w_rr >= {1'b0, r_k}) begin
                w_rr = w_rr - {1'b0, r_k};
                w_qbyte[sfs_pkg::DIV_CHUNK-1-i] = 1'b1;
            end
            w_rem = w_rr[sfs_pkg::K_W-1:0];
        end
    end

    always_comb begin
        case (r_state)
            ST_S0: begin
                w_ma = 33'(w_a);
                w_mb = sfs_pkg::PI_Q30;
            end
            ST_S1: begin
                w_ma = w_xn;
                w_mb = w_xn;
            end
            ST_S2: begin
                w_ma = w_odd ? sfs_pkg::CC8 : sfs_pkg::SC7;
                w_mb = w_rp30;
            end
            ST_S3: begin
                w_ma = w_w3;
                w_mb = r_z;
            end
            ST_S4: begin
                w_ma = w_odd ? r_z : w_w4;
                w_mb = r_z;
            end
            ST_S5: begin
                w_ma = w_odd ? r_w : w_rp30;
                w_mb = w_odd ? w_rp30 : r_x;
            end
            ST_S6: begin
                w_ma = 33'(i_cfg.amplitude);
                w_mb = w_sine;
            end
            ST_FIN0: begin
                w_ma = w_s16;
                w_mb = sfs_pkg::TWO_OVER_PI;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign o_item_pop     = (r_state == ST_IDLE) && i_item_valid;
    assign o_valid        = r_ovalid;
    assign o_sample_value = r_oval;
    assign o_status       = r_ostat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        r_state <= (i_item.cls == sfs_pkg::CLS_RUN) ? ST_S0 : ST_OUT;
                    end
                end
                ST_S0:   r_state <= ST_S1;
                ST_S1:   r_state <= ST_S2;
                ST_S2:   r_state <= ST_S3;
                ST_S3:   r_state <= ST_S4;
                ST_S4:   r_state <= ST_S5;
                ST_S5:   r_state <= ST_S6;
                ST_S6:   r_state <= ST_S7;
                ST_S7:   r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_cnt == ($clog2(sfs_pkg::DIV_STEPS))'(sfs_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    if (8'(r_k) + 8'd1 == i_cfg.harmonic_count) begin
                        r_state <= ST_FIN0;
                    end else begin
                        r_state <= ST_S0;
                    end
                end
                ST_FIN0: r_state <= ST_FIN1;
                ST_FIN1: r_state <= ST_OUT;
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_ma * w_mb;
        case (r_state)
            ST_IDLE: begin
                r_d     <= i_item.step_d;
                r_ph    <= i_item.step_d;
                r_k     <= sfs_pkg::K_W'(1);
                r_sum   <= '0;
                r_res   <= '0;
                r_rstat <= i_item.cls == sfs_pkg::CLS_ERR;
            end
            ST_S0: begin
                r_q   <= w_q;
                r_neg <= w_dd[31];
            end
            ST_S1: r_x <= w_xn;
            ST_S2: r_z <= w_rp30;
            ST_S3: r_w <= w_w3;
            ST_S4: r_w <= w_w4;
            ST_S7: begin
                r_tneg <= r_p[65];
                r_div  <= w_mag[sfs_pkg::DIV_W-1:0]
                          + sfs_pkg::DIV_W'(r_k[sfs_pkg::K_W-1:1]);
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            ST_DIV: begin
                r_div <= r_div << sfs_pkg::DIV_CHUNK;
                r_quo <= {r_quo[sfs_pkg::DIV_W-sfs_pkg::DIV_CHUNK-1:0], w_qbyte};
                r_rem <= w_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            ST_ACC: begin
                r_sum <= (r_tneg ^ r_k[0]) ? r_sum - w_term : r_sum + w_term;
                r_k   <= r_k + 1'b1;
                r_ph  <= r_ph + r_d;
            end
            ST_FIN1: begin
                r_res   <= w_sat;
                r_rstat <= 1'b0;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_oval  <= r_res;
                    r_ostat <= r_rstat;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

[design/sawtooth_fourier_synth.sv]
// Top level of the sawtooth Fourier synthesizer: configuration registers, front, queue, back.
// Depends on sfs_pkg, sfs_front, sfs_fifo and sfs_back.
//
// Usage:
//   Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   amplitude (0), phase_step (1), harmonic_count (2), reverse_mode (3); other indexes
//   are dropped. o_cfg_ready is always high. Write only while the block is idle.
//   Input channel (i_valid/o_ready, i_sample_index) takes one sample request.
//   Output channel (o_valid/i_ready, o_sample_value, o_status) returns one result each.
//   Per request: after the front and queue, each of harmonic_count-1 harmonics runs the
//   sine on the shared multiplier, a divide by k and an accumulate, then the final
//   scaling follows; error and trivial counts skip the harmonics and the scaling.
//   Requests are processed by the back end one at a time; the front and a 2-entry
//   queue keep accepting while the back end works or a result waits, until they are full.
//   Reset clears all control state and loads the register defaults.
//   When the receiver stalls, the result holds in the output register and the back
//   end waits with the next finished result until it is taken.
`default_nettype none

module sawtooth_fourier_synth (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_sample_index,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_sample_value,
    output logic             o_status
);

    logic signed [23:0] r_amplitude;
    logic [31:0]        r_phase_step;
    logic [7:0]         r_harmonic_count;
    logic               r_reverse_mode;

    logic               w_push;
    logic               w_push_ready;
    sfs_pkg::t_item     w_front_item;
    logic               w_q_valid;
    sfs_pkg::t_item     w_q_item;
    logic               w_pop;
    sfs_pkg::t_cfg      w_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude      <= 24'sd65536;
            r_phase_step     <= 32'd16777216;
            r_harmonic_count <= 8'd16;
            r_reverse_mode   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sfs_pkg::REG_AMPLITUDE:      r_amplitude      <= i_cfg_data[23:0];
                sfs_pkg::REG_PHASE_STEP:     r_phase_step     <= i_cfg_data;
                sfs_pkg::REG_HARMONIC_COUNT: r_harmonic_count <= i_cfg_data[7:0];
                sfs_pkg::REG_REVERSE_MODE:   r_reverse_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.amplitude      = r_amplitude;
    assign w_cfg.harmonic_count = r_harmonic_count;
    assign w_cfg.reverse_mode   = r_reverse_mode;

    sfs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample_index   (i_sample_index),
        .i_phase_step     (r_phase_step),
        .i_harmonic_count (r_harmonic_count),
        .o_push           (w_push),
        .o_item           (w_front_item),
        .i_push_ready     (w_push_ready)
    );

    sfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_push_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    sfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (w_q_valid),
        .i_item         (w_q_item),
        .o_item_pop     (w_pop),
        .i_cfg          (w_cfg),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_value (o_sample_value),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire
